/* rtl/hgclf_pkg.sv */
// Shared types, codes, constants and arithmetic helpers of the horizon goal clip unit.
`default_nettype none

package hgclf_pkg;

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE, S_SQA, S_SQB, S_CMP, S_PASS, S_VEC, S_ROT1, S_NPOS, S_ROT2, S_QUAT,
      S_SQRT, S_DIVN, S_NSET, S_EINT, S_DIVX, S_DIVY, S_FILL, S_EGOAL
   } state_type;

   // Point kinds on the result word
   localparam logic [1:0] KIND_INTERMEDIATE = 2'd0;
   localparam logic [1:0] KIND_FILL         = 2'd1;
   localparam logic [1:0] KIND_GOAL         = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESOLUTION = 2'd1;

   localparam logic [30:0] HORIZON_RESET    = 31'd655360;
   localparam logic [30:0] RESOLUTION_RESET = 31'd3277;

   // CORDIC datapath and binary angle widths
   localparam int CW = 50;
   localparam int AW = 34;
   localparam logic signed [AW-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic [30:0] KINV_Q30 = 31'd652032874;

   // Loop end counts
   localparam logic [5:0] SQ_LAST   = 6'd32;
   localparam logic [5:0] SQRT_LAST = 6'd33;
   localparam logic [5:0] DIV_LAST  = 6'd35;

   // Arctangent of 2^-i as a 32-bit binary angle
   function automatic logic signed [AW-1:0] atan_val(input logic [4:0] i);
      logic signed [AW-1:0] r;
      case (i)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         5'd30: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   // Round off 16 fraction bits, ties toward +infinity
   function automatic logic signed [34:0] rnd16(input logic signed [CW-1:0] v);
      logic signed [CW:0] t;
      t = {v[CW-1], v} + 51'sd32768;
      return 35'(t >>> 16);
   endfunction

   // Magnitude of a 33-bit signed difference
   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

endpackage

`default_nettype wire

/* rtl/horizon_goal_clip_and_line_fill_unit.sv */
// Top level: clips a goal to the horizon radius and fills the remaining line with points.
//
// Usage: a request word (start, goal, goal quaternion) enters on req_* with
// valid/stall. Results leave on rsp_* with valid/stall, one word per point;
// last_point marks the final word of a request. csr_* writes horizon_distance
// (index 0) and step_resolution (index 1); the user writes them only while
// the unit is idle, which the block itself does not enforce. A goal within
// the horizon gives a single word. A clipped goal runs a shared sequential
// datapath: 33-step shift-add squarings, three CORDIC passes of CORDIC_STEPS
// steps each, a 34-step square root and a 36-step restoring division to the
// intermediate word, then, with fill points, two more such divisions and one
// fill word per cycle while rsp_stall is low, then the goal word. One request
// is worked on at a time; req_stall is high from acceptance until the last
// word of the request is in the output register. The output register holds a
// word while rsp_stall is high and the sequencer waits on it. Reset returns
// to idle, drops any pending word and loads the register reset values.
`default_nettype none

module horizon_goal_clip_and_line_fill_unit #(
   parameter int MAX_FILL_POINTS = 62,
   parameter int CORDIC_STEPS    = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [hgclf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [30:0]                        csr_write_data,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic signed [31:0]                 req_start_x,
   input  wire logic signed [31:0]                 req_start_y,
   input  wire logic signed [31:0]                 req_goal_x,
   input  wire logic signed [31:0]                 req_goal_y,
   input  wire logic signed [15:0]                 req_goal_qw,
   input  wire logic signed [15:0]                 req_goal_qx,
   input  wire logic signed [15:0]                 req_goal_qy,
   input  wire logic signed [15:0]                 req_goal_qz,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [1:0]                         rsp_point_kind,
   output      logic signed [31:0]                 rsp_point_x,
   output      logic signed [31:0]                 rsp_point_y,
   output      logic signed [15:0]                 rsp_quat_w,
   output      logic signed [15:0]                 rsp_quat_x,
   output      logic signed [15:0]                 rsp_quat_y,
   output      logic signed [15:0]                 rsp_quat_z,
   output      logic                               rsp_count_clamped,
   output      logic                               rsp_last_point
);

   localparam int CW = hgclf_pkg::CW;
   localparam int AW = hgclf_pkg::AW;
   localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
   localparam logic [5:0] FILL_MAX    = 6'(MAX_FILL_POINTS);

   hgclf_pkg::state_type state_ff, state_in;

   logic [30:0] horizon_ff, horizon_in, resol_ff, resol_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        round_ff, round_in;

   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic signed [15:0] gqw_ff, gqw_in, gqx_ff, gqx_in, gqy_ff, gqy_in, gqz_ff, gqz_in;
   logic signed [32:0] da_ff, da_in, db_ff, db_in;
   logic [61:0]        hh_ff, hh_in;
   logic [66:0]        acc_ff, acc_in;
   logic [65:0]        mcand_ff, mcand_in;
   logic [32:0]        mbits_ff, mbits_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AW-1:0] ang_ff, ang_in, cz_ff, cz_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [15:0] qw_ff, qw_in, qz_ff, qz_in;
   logic [67:0]        rad_ff, rad_in;
   logic [35:0]        srem_ff, srem_in;
   logic [33:0]        root_ff, root_in;
   logic [35:0]        dnum_ff, dnum_in;
   logic [30:0]        drem_ff, drem_in, dden_ff, dden_in;
   logic [5:0]         fill_n_ff, fill_n_in, idx_ff, idx_in;
   logic               clamped_ff, clamped_in;
   logic [33:0]        quox_ff, quox_in, quoy_ff, quoy_in, accx_ff, accx_in, accy_ff, accy_in;
   logic [6:0]         remx_ff, remx_in, remy_ff, remy_in;
   logic [7:0]         racx_ff, racx_in, racy_ff, racy_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         okind_ff, okind_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [15:0] oqw_ff, oqw_in, oqx_ff, oqx_in, oqy_ff, oqy_in, oqz_ff, oqz_in;
   logic               oclamp_ff, oclamp_in, olast_ff, olast_in;

   logic req_take, out_free, emit_go;
   logic [61:0] mprod;
   logic [30:0] mul_b;
   logic [30:0] res_eff;

   // Shared unit signals
   logic [4:0]           sh;
   logic signed [CW-1:0] xs, ys;
   logic signed [AW-1:0] at, a_cur, a_step;
   logic                 rot_up;
   logic [37:0]          sq_rem2, sq_trial;
   logic [31:0]          dv_r2;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != hgclf_pkg::S_IDLE);
   assign res_eff   = (resol_ff == 31'd0) ? 31'd1 : resol_ff;

   // One multiplier: horizon squared at acceptance, scaled horizon for the first rotation
   assign mul_b = (state_ff == hgclf_pkg::S_IDLE) ? horizon_ff : hgclf_pkg::KINV_Q30;
   assign mprod = 62'(horizon_ff) * 62'(mul_b);

   // CORDIC micro-rotation shared by vectoring and both rotations
   assign sh     = cnt_ff[4:0];
   assign xs     = cx_ff >>> sh;
   assign ys     = cy_ff >>> sh;
   assign at     = hgclf_pkg::atan_val(sh);
   assign rot_up = (state_ff == hgclf_pkg::S_VEC) ? cy_ff[CW-1] : !cz_ff[AW-1];
   assign a_cur  = (state_ff == hgclf_pkg::S_VEC) ? ang_ff : cz_ff;
   assign a_step = rot_up ? (a_cur - at) : (a_cur + at);

   // Square root and divider steps
   assign sq_rem2  = {srem_ff, rad_ff[67:66]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign dv_r2    = {drem_ff, dnum_ff[35]};

   // Configuration registers
   always_comb begin
      horizon_in = horizon_ff;
      resol_in   = resol_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hgclf_pkg::CSR_HORIZON:    horizon_in = csr_write_data;
            hgclf_pkg::CSR_RESOLUTION: resol_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hgclf_pkg::S_IDLE:  if (req_take) state_in = hgclf_pkg::S_SQA;
         hgclf_pkg::S_SQA:   if (cnt_ff == hgclf_pkg::SQ_LAST) state_in = hgclf_pkg::S_SQB;
         hgclf_pkg::S_SQB: begin
            if (cnt_ff == hgclf_pkg::SQ_LAST)
               state_in = round_ff ? hgclf_pkg::S_SQRT : hgclf_pkg::S_CMP;
         end
         hgclf_pkg::S_CMP: begin
            state_in = (acc_ff > {5'd0, hh_ff}) ? hgclf_pkg::S_VEC : hgclf_pkg::S_PASS;
         end
         hgclf_pkg::S_PASS:  if (out_free) state_in = hgclf_pkg::S_IDLE;
         hgclf_pkg::S_VEC:   if (cnt_ff == CORDIC_LAST) state_in = hgclf_pkg::S_ROT1;
         hgclf_pkg::S_ROT1:  if (cnt_ff == CORDIC_LAST) state_in = hgclf_pkg::S_NPOS;
         hgclf_pkg::S_NPOS:  state_in = hgclf_pkg::S_ROT2;
         hgclf_pkg::S_ROT2:  if (cnt_ff == CORDIC_LAST) state_in = hgclf_pkg::S_QUAT;
         hgclf_pkg::S_QUAT:  state_in = hgclf_pkg::S_SQA;
         hgclf_pkg::S_SQRT:  if (cnt_ff == hgclf_pkg::SQRT_LAST) state_in = hgclf_pkg::S_DIVN;
         hgclf_pkg::S_DIVN:  if (cnt_ff == hgclf_pkg::DIV_LAST) state_in = hgclf_pkg::S_NSET;
         hgclf_pkg::S_NSET:  state_in = hgclf_pkg::S_EINT;
         hgclf_pkg::S_EINT: begin
            if (out_free)
               state_in = (fill_n_ff == 6'd0) ? hgclf_pkg::S_EGOAL : hgclf_pkg::S_DIVX;
         end
         hgclf_pkg::S_DIVX:  if (cnt_ff == hgclf_pkg::DIV_LAST) state_in = hgclf_pkg::S_DIVY;
         hgclf_pkg::S_DIVY:  if (cnt_ff == hgclf_pkg::DIV_LAST) state_in = hgclf_pkg::S_FILL;
         hgclf_pkg::S_FILL: begin
            if (out_free && (idx_ff == fill_n_ff - 6'd1)) state_in = hgclf_pkg::S_EGOAL;
         end
         hgclf_pkg::S_EGOAL: if (out_free) state_in = hgclf_pkg::S_IDLE;
         default:            state_in = hgclf_pkg::S_IDLE;
      endcase
   end

   // Datapath and result word
   always_comb begin
      logic signed [CW-1:0] x0;
      logic signed [AW-1:0] z0;
      logic signed [34:0]   r16a, r16b;
      logic signed [35:0]   sumx, sumy;
      logic signed [32:0]   ex, ey;
      logic [34:0]          offx, offy;
      logic signed [34:0]   px, py;
      logic [7:0]           two_n, rx, ry;
      logic [33:0]          qx, qy;

      x0 = '0; z0 = '0; r16a = '0; r16b = '0; sumx = '0; sumy = '0;
      ex = '0; ey = '0; offx = '0; offy = '0; px = '0; py = '0;
      two_n = {1'b0, fill_n_ff, 1'b0};
      rx = '0; ry = '0; qx = '0; qy = '0;

      cnt_in = cnt_ff; round_in = round_ff;
      sx_in = sx_ff; sy_in = sy_ff; gx_in = gx_ff; gy_in = gy_ff;
      gqw_in = gqw_ff; gqx_in = gqx_ff; gqy_in = gqy_ff; gqz_in = gqz_ff;
      da_in = da_ff; db_in = db_ff; hh_in = hh_ff;
      acc_in = acc_ff; mcand_in = mcand_ff; mbits_in = mbits_ff;
      cx_in = cx_ff; cy_in = cy_ff; ang_in = ang_ff; cz_in = cz_ff;
      nx_in = nx_ff; ny_in = ny_ff; qw_in = qw_ff; qz_in = qz_ff;
      rad_in = rad_ff; srem_in = srem_ff; root_in = root_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff;
      fill_n_in = fill_n_ff; clamped_in = clamped_ff; idx_in = idx_ff;
      quox_in = quox_ff; quoy_in = quoy_ff; remx_in = remx_ff; remy_in = remy_ff;
      accx_in = accx_ff; accy_in = accy_ff; racx_in = racx_ff; racy_in = racy_ff;

      emit_go = 1'b0;
      okind_in = okind_ff; ox_in = ox_ff; oy_in = oy_ff;
      oqw_in = oqw_ff; oqx_in = oqx_ff; oqy_in = oqy_ff; oqz_in = oqz_ff;
      oclamp_in = oclamp_ff; olast_in = olast_ff;

      case (state_ff)
         // Latch the request and start squaring dx
         hgclf_pkg::S_IDLE: begin
            if (req_take) begin
               sx_in = req_start_x; sy_in = req_start_y;
               gx_in = req_goal_x;  gy_in = req_goal_y;
               gqw_in = req_goal_qw; gqx_in = req_goal_qx;
               gqy_in = req_goal_qy; gqz_in = req_goal_qz;
               ex = 33'(req_goal_x) - 33'(req_start_x);
               ey = 33'(req_goal_y) - 33'(req_start_y);
               da_in = ex; db_in = ey;
               hh_in = mprod;
               acc_in = '0;
               mcand_in = 66'(hgclf_pkg::mag33(ex));
               mbits_in = hgclf_pkg::mag33(ex);
               cnt_in = '0;
               round_in = 1'b0;
               clamped_in = 1'b0;
            end
         end
         // Shift-add squaring, first operand then second
         hgclf_pkg::S_SQA, hgclf_pkg::S_SQB: begin
            if (mbits_ff[0]) acc_in = acc_ff + 67'(mcand_ff);
            mcand_in = {mcand_ff[64:0], 1'b0};
            mbits_in = {1'b0, mbits_ff[32:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == hgclf_pkg::SQ_LAST) begin
               cnt_in = '0;
               if (state_ff == hgclf_pkg::S_SQA) begin
                  mcand_in = 66'(hgclf_pkg::mag33(db_ff));
                  mbits_in = hgclf_pkg::mag33(db_ff);
               end else begin
                  rad_in = {1'b0, acc_in};
                  srem_in = '0;
                  root_in = '0;
               end
            end
         end
         // Set up vectoring, folding the left half plane
         hgclf_pkg::S_CMP: begin
            cnt_in = '0;
            if (da_ff[32]) begin
               cx_in = -CW'(da_ff);
               cy_in = -CW'(db_ff);
               ang_in = db_ff[32] ? -hgclf_pkg::HALF_TURN : hgclf_pkg::HALF_TURN;
            end else begin
               cx_in = CW'(da_ff);
               cy_in = CW'(db_ff);
               ang_in = '0;
            end
         end
         // Goal inside the horizon passes through
         hgclf_pkg::S_PASS: begin
            if (out_free) begin
               emit_go = 1'b1;
               okind_in = hgclf_pkg::KIND_INTERMEDIATE;
               ox_in = gx_ff; oy_in = gy_ff;
               oqw_in = gqw_ff; oqx_in = gqx_ff; oqy_in = gqy_ff; oqz_in = gqz_ff;
               oclamp_in = 1'b0; olast_in = 1'b1;
            end
         end
         // CORDIC iterations
         hgclf_pkg::S_VEC, hgclf_pkg::S_ROT1, hgclf_pkg::S_ROT2: begin
            cx_in = rot_up ? (cx_ff - ys) : (cx_ff + ys);
            cy_in = rot_up ? (cy_ff + xs) : (cy_ff - xs);
            if (state_ff == hgclf_pkg::S_VEC) ang_in = a_step;
            else cz_in = a_step;
            cnt_in = cnt_ff + 6'd1;
            if ((state_ff == hgclf_pkg::S_VEC) && (cnt_ff == CORDIC_LAST)) begin
               x0 = CW'({2'b00, mprod[61:14]});
               z0 = a_step;
               cnt_in = '0;
               cy_in = '0;
               if (z0 > hgclf_pkg::QUARTER_TURN) begin
                  cz_in = z0 - hgclf_pkg::HALF_TURN; cx_in = -x0;
               end else if (z0 < -hgclf_pkg::QUARTER_TURN) begin
                  cz_in = z0 + hgclf_pkg::HALF_TURN; cx_in = -x0;
               end else begin
                  cz_in = z0; cx_in = x0;
               end
            end
         end
         // Intermediate position, then set up the half-angle rotation
         hgclf_pkg::S_NPOS: begin
            r16a = hgclf_pkg::rnd16(cx_ff);
            r16b = hgclf_pkg::rnd16(cy_ff);
            sumx = 36'(sx_ff) + 36'(r16a);
            sumy = 36'(sy_ff) + 36'(r16b);
            nx_in = (sumx > 36'sd2147483647) ? 32'sh7fffffff :
                    (sumx < -36'sd2147483648) ? 32'sh80000000 : sumx[31:0];
            ny_in = (sumy > 36'sd2147483647) ? 32'sh7fffffff :
                    (sumy < -36'sd2147483648) ? 32'sh80000000 : sumy[31:0];
            x0 = CW'(hgclf_pkg::KINV_Q30);
            z0 = ang_ff >>> 1;
            cnt_in = '0;
            cy_in = '0;
            if (z0 > hgclf_pkg::QUARTER_TURN) begin
               cz_in = z0 - hgclf_pkg::HALF_TURN; cx_in = -x0;
            end else if (z0 < -hgclf_pkg::QUARTER_TURN) begin
               cz_in = z0 + hgclf_pkg::HALF_TURN; cx_in = -x0;
            end else begin
               cz_in = z0; cx_in = x0;
            end
         end
         // Quaternion and remaining span, start its squaring
         hgclf_pkg::S_QUAT: begin
            r16a = hgclf_pkg::rnd16(cx_ff);
            r16b = hgclf_pkg::rnd16(cy_ff);
            qw_in = (r16a > 35'sd16384) ? 16'sd16384 :
                    (r16a < -35'sd16384) ? -16'sd16384 : r16a[15:0];
            qz_in = (r16b > 35'sd16384) ? 16'sd16384 :
                    (r16b < -35'sd16384) ? -16'sd16384 : r16b[15:0];
            ex = 33'(gx_ff) - 33'(nx_ff);
            ey = 33'(gy_ff) - 33'(ny_ff);
            da_in = ex; db_in = ey;
            acc_in = '0;
            mcand_in = 66'(hgclf_pkg::mag33(ex));
            mbits_in = hgclf_pkg::mag33(ex);
            cnt_in = '0;
            round_in = 1'b1;
         end
         // Digit-by-digit square root
         hgclf_pkg::S_SQRT: begin
            if (sq_rem2 >= sq_trial) begin
               srem_in = 36'(sq_rem2 - sq_trial);
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               srem_in = sq_rem2[35:0];
               root_in = {root_ff[32:0], 1'b0};
            end
            rad_in = {rad_ff[65:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == hgclf_pkg::SQRT_LAST) begin
               cnt_in = '0;
               dnum_in = {2'b00, root_in};
               drem_in = '0;
               dden_in = res_eff;
            end
         end
         // Restoring division
         hgclf_pkg::S_DIVN, hgclf_pkg::S_DIVX, hgclf_pkg::S_DIVY: begin
            if (dv_r2 >= {1'b0, dden_ff}) begin
               drem_in = 31'(dv_r2 - {1'b0, dden_ff});
               dnum_in = {dnum_ff[34:0], 1'b1};
            end else begin
               drem_in = dv_r2[30:0];
               dnum_in = {dnum_ff[34:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == hgclf_pkg::DIV_LAST) begin
               cnt_in = '0;
               if (state_ff == hgclf_pkg::S_DIVX) begin
                  quox_in = dnum_in[33:0];
                  remx_in = drem_in[6:0];
                  dnum_in = {2'b00, hgclf_pkg::mag33(db_ff), 1'b0};
                  drem_in = '0;
               end else if (state_ff == hgclf_pkg::S_DIVY) begin
                  quoy_in = dnum_in[33:0];
                  remy_in = drem_in[6:0];
                  accx_in = '0; accy_in = '0;
                  racx_in = {2'b00, fill_n_ff};
                  racy_in = {2'b00, fill_n_ff};
                  idx_in = '0;
               end
            end
         end
         // Clamp the fill count
         hgclf_pkg::S_NSET: begin
            if (dnum_ff > 36'(FILL_MAX)) begin
               fill_n_in = FILL_MAX;
               clamped_in = 1'b1;
            end else begin
               fill_n_in = dnum_ff[5:0];
               clamped_in = 1'b0;
            end
         end
         // Emit the intermediate goal, set up the x step division
         hgclf_pkg::S_EINT: begin
            if (out_free) begin
               emit_go = 1'b1;
               okind_in = hgclf_pkg::KIND_INTERMEDIATE;
               ox_in = nx_ff; oy_in = ny_ff;
               oqw_in = qw_ff; oqx_in = '0; oqy_in = '0; oqz_in = qz_ff;
               oclamp_in = clamped_ff; olast_in = 1'b0;
               dnum_in = {2'b00, hgclf_pkg::mag33(da_ff), 1'b0};
               drem_in = '0;
               dden_in = 31'(two_n);
               cnt_in = '0;
            end
         end
         // Emit fill points, advance the running quotients
         hgclf_pkg::S_FILL: begin
            if (out_free) begin
               offx = {1'b0, accx_ff};
               offy = {1'b0, accy_ff};
               px = 35'(nx_ff) + (da_ff[32] ? -35'(offx) : 35'(offx));
               py = 35'(ny_ff) + (db_ff[32] ? -35'(offy) : 35'(offy));
               emit_go = 1'b1;
               okind_in = hgclf_pkg::KIND_FILL;
               ox_in = px[31:0]; oy_in = py[31:0];
               oqw_in = qw_ff; oqx_in = '0; oqy_in = '0; oqz_in = qz_ff;
               oclamp_in = clamped_ff; olast_in = 1'b0;
               rx = racx_ff + {1'b0, remx_ff};
               ry = racy_ff + {1'b0, remy_ff};
               qx = accx_ff + quox_ff;
               qy = accy_ff + quoy_ff;
               if (rx >= two_n) begin
                  rx = rx - two_n; qx = qx + 34'd1;
               end
               if (ry >= two_n) begin
                  ry = ry - two_n; qy = qy + 34'd1;
               end
               racx_in = rx; racy_in = ry;
               accx_in = qx; accy_in = qy;
               idx_in = idx_ff + 6'd1;
            end
         end
         // Emit the goal itself
         hgclf_pkg::S_EGOAL: begin
            if (out_free) begin
               emit_go = 1'b1;
               okind_in = hgclf_pkg::KIND_GOAL;
               ox_in = gx_ff; oy_in = gy_ff;
               oqw_in = gqw_ff; oqx_in = gqx_ff; oqy_in = gqy_ff; oqz_in = gqz_ff;
               oclamp_in = clamped_ff; olast_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Output register valid: load on emit, hold while stalled
   always_comb begin
      if (emit_go) rsp_valid_in = 1'b1;
      else         rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hgclf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         horizon_ff   <= hgclf_pkg::HORIZON_RESET;
         resol_ff     <= hgclf_pkg::RESOLUTION_RESET;
         cnt_ff       <= '0;
         round_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         horizon_ff   <= horizon_in;
         resol_ff     <= resol_in;
         cnt_ff       <= cnt_in;
         round_ff     <= round_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sx_ff <= sx_in; sy_ff <= sy_in; gx_ff <= gx_in; gy_ff <= gy_in;
      gqw_ff <= gqw_in; gqx_ff <= gqx_in; gqy_ff <= gqy_in; gqz_ff <= gqz_in;
      da_ff <= da_in; db_ff <= db_in; hh_ff <= hh_in;
      acc_ff <= acc_in; mcand_ff <= mcand_in; mbits_ff <= mbits_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ang_ff <= ang_in; cz_ff <= cz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; qw_ff <= qw_in; qz_ff <= qz_in;
      rad_ff <= rad_in; srem_ff <= srem_in; root_ff <= root_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in;
      fill_n_ff <= fill_n_in; clamped_ff <= clamped_in; idx_ff <= idx_in;
      quox_ff <= quox_in; quoy_ff <= quoy_in; remx_ff <= remx_in; remy_ff <= remy_in;
      accx_ff <= accx_in; accy_ff <= accy_in; racx_ff <= racx_in; racy_ff <= racy_in;
      okind_ff <= okind_in; ox_ff <= ox_in; oy_ff <= oy_in;
      oqw_ff <= oqw_in; oqx_ff <= oqx_in; oqy_ff <= oqy_in; oqz_ff <= oqz_in;
      oclamp_ff <= oclamp_in; olast_ff <= olast_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_kind    = okind_ff;
   assign rsp_point_x       = ox_ff;
   assign rsp_point_y       = oy_ff;
   assign rsp_quat_w        = oqw_ff;
   assign rsp_quat_x        = oqx_ff;
   assign rsp_quat_y        = oqy_ff;
   assign rsp_quat_z        = oqz_ff;
   assign rsp_count_clamped = oclamp_ff;
   assign rsp_last_point    = olast_ff;

   // Fill index stays below the fill count
   a_fill_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hgclf_pkg::S_FILL) |-> (idx_ff < fill_n_ff))
      else $error("fill index beyond fill count");

   // Running remainders stay below twice the fill count
   a_fill_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hgclf_pkg::S_FILL) |->
         ((racx_ff < {1'b0, fill_n_ff, 1'b0}) && (racy_ff < {1'b0, fill_n_ff, 1'b0})))
      else $error("fill remainder out of range");

   // Fill count never exceeds the clamp
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hgclf_pkg::S_EINT) |-> (fill_n_ff <= FILL_MAX))
      else $error("fill count above maximum");

   // No word is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result word valid after reset");

endmodule

`default_nettype wire
